// ===== rtl/mrc_pkg.sv =====
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types, constants and the CRC-16 byte update for the Modbus RTU
// request checker.
// ----------------------------------------------------------------------------
package mrc_pkg;

    localparam int unsigned LEN_W = 9;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] COIL_ON  = 16'hFF00;
    localparam logic [15:0] COIL_OFF = 16'h0000;

    localparam logic [15:0] MAX_READ_BITS   = 16'd2000;
    localparam logic [15:0] MAX_READ_REGS   = 16'd125;
    localparam logic [15:0] MAX_WRITE_BITS  = 16'd1968;
    localparam logic [15:0] MAX_WRITE_REGS  = 16'd123;

    // Frame lengths including the two CRC bytes.
    localparam logic [LEN_W-1:0] LEN_MIN        = 9'd4;
    localparam logic [LEN_W-1:0] LEN_FIXED      = 9'd8;
    localparam logic [LEN_W-1:0] LEN_MIN_WBITS  = 9'd10;
    localparam logic [LEN_W-1:0] LEN_MIN_WREGS  = 9'd11;

    localparam logic [7:0] FC_READ_COILS      = 8'd1;
    localparam logic [7:0] FC_READ_DISCRETE   = 8'd2;
    localparam logic [7:0] FC_READ_HOLDING    = 8'd3;
    localparam logic [7:0] FC_READ_INPUT      = 8'd4;
    localparam logic [7:0] FC_WRITE_COIL      = 8'd5;
    localparam logic [7:0] FC_WRITE_REG       = 8'd6;
    localparam logic [7:0] FC_WRITE_COILS     = 8'd15;
    localparam logic [7:0] FC_WRITE_REGS      = 8'd16;

    typedef enum logic [2:0] {
        V_ACCEPT      = 3'd0,
        V_TOO_SHORT   = 3'd1,
        V_CRC_BAD     = 3'd2,
        V_OTHER_STN   = 3'd3,
        V_ILLEGAL_FN  = 3'd4,
        V_ILLEGAL_VAL = 3'd5,
        V_OVERFLOW    = 3'd6
    } t_verdict;

    // Frame summary handed from the frame tracker to the verdict logic.
    typedef struct packed {
        logic             overflow;
        logic             crc_match;
        logic [LEN_W-1:0] length;
        logic [7:0]       address;
        logic [7:0]       func;
        logic [15:0]      quantity;
        logic [7:0]       count;
    } t_frame_sum;

    // One byte of the reflected CRC-16 update, unrolled over eight bits.
    function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] v;
        v = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

endpackage

// ===== rtl/mrc_judge.sv =====
// ----------------------------------------------------------------------------
// mrc_judge
// Verdict for one finished frame from its summary and the station address.
// ----------------------------------------------------------------------------
module mrc_judge
    import mrc_pkg::*;
(
    input  t_frame_sum i_sum,
    input  logic [7:0] i_station,
    output t_verdict   o_verdict
);

    logic        qty_nonzero;
    logic        len_fixed;
    logic [16:0] bits_bytes;
    logic [16:0] regs_bytes;
    t_verdict    fn_verdict;

    assign qty_nonzero = (i_sum.quantity != 16'd0);
    assign len_fixed   = (i_sum.length == LEN_FIXED);
    // Byte count expected for multiple writes: ceil(q/8) for coils, 2q for registers.
    assign bits_bytes  = ({1'b0, i_sum.quantity} + 17'd7) >> 3;
    assign regs_bytes  = {i_sum.quantity, 1'b0};

    always_comb begin
        case (i_sum.func)
            FC_READ_COILS, FC_READ_DISCRETE: begin
                fn_verdict = (len_fixed && qty_nonzero && i_sum.quantity <= MAX_READ_BITS)
                           ? V_ACCEPT : V_ILLEGAL_VAL;
            end
            FC_READ_HOLDING, FC_READ_INPUT: begin
                fn_verdict = (len_fixed && qty_nonzero && i_sum.quantity <= MAX_READ_REGS)
                           ? V_ACCEPT : V_ILLEGAL_VAL;
            end
            FC_WRITE_COIL: begin
                fn_verdict = (len_fixed && (i_sum.quantity == COIL_OFF
                                            || i_sum.quantity == COIL_ON))
                           ? V_ACCEPT : V_ILLEGAL_VAL;
            end
            FC_WRITE_REG: begin
                fn_verdict = len_fixed ? V_ACCEPT : V_ILLEGAL_VAL;
            end
            FC_WRITE_COILS: begin
                fn_verdict = (i_sum.length >= LEN_MIN_WBITS && qty_nonzero
                              && i_sum.quantity <= MAX_WRITE_BITS
                              && bits_bytes == {9'd0, i_sum.count})
                           ? V_ACCEPT : V_ILLEGAL_VAL;
            end
            FC_WRITE_REGS: begin
                fn_verdict = (i_sum.length >= LEN_MIN_WREGS && qty_nonzero
                              && i_sum.quantity <= MAX_WRITE_REGS
                              && regs_bytes == {9'd0, i_sum.count})
                           ? V_ACCEPT : V_ILLEGAL_VAL;
            end
            default: begin
                fn_verdict = V_ILLEGAL_FN;
            end
        endcase
    end

    always_comb begin
        if (i_sum.overflow) begin
            o_verdict = V_OVERFLOW;
        end else if (i_sum.length < LEN_MIN) begin
            o_verdict = V_TOO_SHORT;
        end else if (!i_sum.crc_match) begin
            o_verdict = V_CRC_BAD;
        end else if (i_sum.address != i_station) begin
            o_verdict = V_OTHER_STN;
        end else begin
            o_verdict = fn_verdict;
        end
    end

endmodule

// ===== rtl/modbus_rtu_request_checker.sv =====
// ----------------------------------------------------------------------------
// modbus_rtu_request_checker
// Checks received Modbus RTU request frames byte by byte and reports a
// verdict with the decoded header at each frame end.
// ----------------------------------------------------------------------------
// A frame's last byte is loaded into the input register, and its result then into
// the result register once that register can take it. Throughput: one byte per
// cycle; a last byte waits only while a result is held unaccepted.
// Reset (i_rst_n low, synchronous) empties both registers, clears the frame
// state and sets the station address to 1.
// ----------------------------------------------------------------------------
module modbus_rtu_request_checker
    import mrc_pkg::*;
#(
    parameter int unsigned MAX_FRAME = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: station address.
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    // Received bytes.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tlast,   // frame_end
    // Frame results.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] verdict, [10:3] function_code, [26:11] start_address,
    // [42:27] quantity_or_value, [50:43] declared_byte_count,
    // [59:51] frame_length, [63:60] zero
    output logic [63:0] m_axis_tdata
);

    localparam int unsigned CNT_W = $clog2(MAX_FRAME + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME);
    localparam int unsigned HDR_N = 7;

    // The input register decouples the byte stream from the frame state.
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;

    logic [7:0]       r_station;

    // Frame state, cleared at every frame end.
    logic [15:0]      r_crc,  n_crc;
    logic [CNT_W-1:0] r_cnt,  n_cnt;
    logic [7:0]       r_tail [2];
    logic [7:0]       n_tail [2];
    logic [7:0]       r_hdr  [HDR_N];
    logic [7:0]       n_hdr  [HDR_N];
    logic             r_ovf,  n_ovf;

    // Result register.
    logic             r_out_valid;
    logic [63:0]      r_out_data;

    logic             out_free;
    logic             process;
    t_frame_sum       sum;
    t_verdict         verdict;

    assign out_free = !r_out_valid || m_axis_tready;
    // A byte that ends a frame waits until the result register can take it;
    // other bytes move on regardless.
    assign process  = r_in_valid && (!r_in_last || out_free);
    assign s_axis_tready = !r_in_valid || process;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station <= 8'd1;
        end else if (i_cfg_wr_en) begin
            r_station <= i_cfg_wr_data;
        end
    end

    // Frame state after the byte in the input register. The CRC lags two
    // bytes behind so that the two trailing CRC bytes are never fed in.
    always_comb begin
        n_crc  = r_crc;
        n_cnt  = r_cnt;
        n_tail = r_tail;
        n_hdr  = r_hdr;
        n_ovf  = r_ovf;
        if (r_cnt >= CNT_MAX) begin
            n_ovf = 1'b1;
        end else begin
            if (r_cnt >= CNT_W'(2)) begin
                n_crc = crc_feed(r_crc, r_tail[0]);
            end
            n_tail[0] = r_tail[1];
            n_tail[1] = r_in_byte;
            for (int i = 0; i < HDR_N; i++) begin
                if (r_cnt == CNT_W'(i)) begin
                    n_hdr[i] = r_in_byte;
                end
            end
            n_cnt = r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (process && r_in_last)) begin
            r_crc  <= CRC_INIT;
            r_cnt  <= '0;
            r_ovf  <= 1'b0;
            for (int i = 0; i < 2; i++) begin
                r_tail[i] <= 8'd0;
            end
            for (int i = 0; i < HDR_N; i++) begin
                r_hdr[i] <= 8'd0;
            end
        end else if (process) begin
            r_crc  <= n_crc;
            r_cnt  <= n_cnt;
            r_ovf  <= n_ovf;
            r_tail <= n_tail;
            r_hdr  <= n_hdr;
        end
    end

    assign sum.overflow  = n_ovf;
    assign sum.crc_match = ({n_tail[1], n_tail[0]} == n_crc);
    assign sum.length    = LEN_W'(n_cnt);
    assign sum.address   = n_hdr[0];
    assign sum.func      = n_hdr[1];
    assign sum.quantity  = {n_hdr[4], n_hdr[5]};
    assign sum.count     = n_hdr[6];

    mrc_judge u_judge (
        .i_sum     (sum),
        .i_station (r_station),
        .o_verdict (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= process && r_in_last;
        end
        if (out_free && process && r_in_last) begin
            r_out_data <= {4'd0, sum.length, sum.count, sum.quantity,
                           n_hdr[2], n_hdr[3], sum.func, verdict};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ===== rtl/mrc_checker.sv =====
// ----------------------------------------------------------------------------
// mrc_checker
// Port-level checks on the request checker's result stream.
// ----------------------------------------------------------------------------
module mrc_checker
    import mrc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);

    logic [2:0]       v;
    logic [LEN_W-1:0] len;

    assign v   = m_axis_tdata[2:0];
    assign len = m_axis_tdata[59:51];

    // A stalled result stays on the bus.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // No result can be pending straight after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A frame judged too short has fewer than four bytes.
    a_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && v == V_TOO_SHORT |-> len < LEN_MIN)
        else $error("too-short verdict with long frame");

    // An accepted request carries at least the fixed eight bytes.
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && v == V_ACCEPT |-> len >= LEN_FIXED)
        else $error("accepted frame shorter than eight bytes");

    // Padding bits stay zero and the verdict is a defined code.
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[63:60] == 4'd0 && v != 3'd7)
        else $error("bad verdict code or padding");

endmodule

bind modbus_rtu_request_checker mrc_checker u_mrc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Modbus RTU request checker. Frames are sent one
// byte per item on the input stream. A model of the checker, kept inside the
// bench, works out the verdict and the decoded header of each frame, and the
// result stream is compared with it field by field. Directed frames cover
// every function code, every verdict and the frame-size limit. Random
// traffic, mostly well-formed requests with random content, follows at three
// idling settings.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mrc_pkg::*;

    localparam int FRAME_CAP      = 256;
    localparam int RESET_CYCLES   = 10;
    localparam int SETTLE_CYCLES  = 4;     // extra wait once all results are taken
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_PRINTED    = 40;
    localparam logic [7:0] EXC_FLAG = 8'h80;

    // Decoded form of one result item.
    typedef struct packed {
        t_verdict         verdict;
        logic [7:0]       func;
        logic [15:0]      start_addr;
        logic [15:0]      quantity;
        logic [7:0]       byte_count;
        logic [LEN_W-1:0] length;
    } t_frame_report;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [7:0]  i_cfg_wr_data = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;   // [7:0] rx_byte
    logic        s_axis_tlast  = 1'b0;   // frame_end
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [2:0] verdict, [10:3] function_code, [26:11] start_address,
    // [42:27] quantity_or_value, [50:43] declared_byte_count,
    // [59:51] frame_length, [63:60] zero
    logic [63:0] m_axis_tdata;

    modbus_rtu_request_checker #(
        .MAX_FRAME (FRAME_CAP)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Model of the checker. Its state mirrors the per-frame state of the block:
    // the running CRC, the number of bytes held, the last two bytes (which
    // turn out to be the received CRC once the frame ends), the first seven
    // bytes as the header, and the overflow mark.
    // ------------------------------------------------------------------------
    logic [7:0]    station_addr = 8'd1;
    logic [15:0]   crc_acc;
    int            held_count;
    logic [7:0]    tail_q [2];
    logic [7:0]    hdr_q [7];
    bit            frame_overflow;
    t_frame_report pending_reports [$];

    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int error_count     = 0;
    int bytes_sent      = 0;
    int frames_sent     = 0;
    int results_checked = 0;
    int verdict_tally [7];

    // Reflected CRC-16, one data bit at a time from the least significant.
    function automatic logic [15:0] crc16_next(input logic [15:0] acc,
                                               input logic [7:0] data);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int k = 0; k < 8; k++) begin
            fb = r[0] ^ data[k];
            r  = r >> 1;
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    function automatic void clear_frame_state();
        crc_acc        = CRC_INIT;
        held_count     = 0;
        frame_overflow = 1'b0;
        foreach (tail_q[i]) tail_q[i] = 8'd0;
        foreach (hdr_q[i]) hdr_q[i] = 8'd0;
    endfunction

    // Verdict of the frame now held. The checks run in a fixed order: the
    // first that fails decides. Lengths here include the two CRC bytes.
    function automatic t_verdict judge_frame();
        logic [7:0]  fc;
        logic [15:0] qty;
        logic [7:0]  cnt;
        logic [15:0] got_crc;
        fc      = hdr_q[1];
        qty     = {hdr_q[4], hdr_q[5]};
        cnt     = hdr_q[6];
        got_crc = {tail_q[1], tail_q[0]};
        if (frame_overflow) return V_OVERFLOW;
        if (held_count < LEN_MIN) return V_TOO_SHORT;
        if (got_crc != crc_acc) return V_CRC_BAD;
        // Address 0 is not treated as broadcast: it must match like any other.
        if (hdr_q[0] != station_addr) return V_OTHER_STN;
        case (fc)
            FC_READ_COILS, FC_READ_DISCRETE:
                return (held_count == LEN_FIXED && qty >= 1 && qty <= MAX_READ_BITS)
                       ? V_ACCEPT : V_ILLEGAL_VAL;
            FC_READ_HOLDING, FC_READ_INPUT:
                return (held_count == LEN_FIXED && qty >= 1 && qty <= MAX_READ_REGS)
                       ? V_ACCEPT : V_ILLEGAL_VAL;
            FC_WRITE_COIL:
                return (held_count == LEN_FIXED && (qty == COIL_OFF || qty == COIL_ON))
                       ? V_ACCEPT : V_ILLEGAL_VAL;
            FC_WRITE_REG:
                return (held_count == LEN_FIXED) ? V_ACCEPT : V_ILLEGAL_VAL;
            FC_WRITE_COILS: begin
                if (held_count < LEN_MIN_WBITS || qty < 1 || qty > MAX_WRITE_BITS)
                    return V_ILLEGAL_VAL;
                return (int'(cnt) == (int'(qty) + 7) / 8) ? V_ACCEPT : V_ILLEGAL_VAL;
            end
            FC_WRITE_REGS: begin
                if (held_count < LEN_MIN_WREGS || qty < 1 || qty > MAX_WRITE_REGS)
                    return V_ILLEGAL_VAL;
                return (int'(cnt) == 2 * int'(qty)) ? V_ACCEPT : V_ILLEGAL_VAL;
            end
            default:
                return V_ILLEGAL_FN;
        endcase
    endfunction

    // Takes one accepted input item into the model. The CRC lags two bytes
    // behind, so that the final two bytes never enter it. Once the frame cap
    // is reached, further bytes are dropped and only mark the frame.
    function automatic void track_rx_byte(input logic [7:0] b, input logic last);
        t_frame_report rep;
        if (held_count >= FRAME_CAP) begin
            frame_overflow = 1'b1;
        end else begin
            if (held_count >= 2) begin
                crc_acc = crc16_next(crc_acc, tail_q[0]);
            end
            tail_q[0] = tail_q[1];
            tail_q[1] = b;
            if (held_count < 7) begin
                hdr_q[held_count] = b;
            end
            held_count++;
        end
        if (last) begin
            // Header bytes never received read as zero; in short frames they
            // may hold CRC bytes and are reported as they are.
            rep.verdict    = judge_frame();
            rep.func       = hdr_q[1];
            rep.start_addr = {hdr_q[2], hdr_q[3]};
            rep.quantity   = {hdr_q[4], hdr_q[5]};
            rep.byte_count = hdr_q[6];
            rep.length     = LEN_W'(held_count);
            pending_reports.push_back(rep);
            verdict_tally[int'(rep.verdict)]++;
            frames_sent++;
            clear_frame_state();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result checking, receiver stalls and the watchdog.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        if (error_count <= MAX_PRINTED) begin
            $display("mismatch at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got,
                     want);
        end
    endtask

    task automatic check_result(input logic [63:0] word);
        t_frame_report want;
        if (pending_reports.size() == 0) begin
            report_mismatch("result with no frame outstanding", word, 64'd0);
            return;
        end
        want = pending_reports.pop_front();
        results_checked++;
        if (word[2:0] != want.verdict)
            report_mismatch("verdict", word[2:0], want.verdict);
        if (word[10:3] != want.func)
            report_mismatch("function code", word[10:3], want.func);
        if (word[26:11] != want.start_addr)
            report_mismatch("start address", word[26:11], want.start_addr);
        if (word[42:27] != want.quantity)
            report_mismatch("quantity or value", word[42:27], want.quantity);
        if (word[50:43] != want.byte_count)
            report_mismatch("byte count", word[50:43], want.byte_count);
        if (word[59:51] != want.length)
            report_mismatch("frame length", word[59:51], want.length);
        if (word[63:60] != 4'd0)
            report_mismatch("padding bits", word[63:60], 64'd0);
    endtask

    // Outputs are sampled at the rising edge, before the block's own updates
    // of that edge take effect, so an accepted result is the one that was held.
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            check_result(m_axis_tdata);
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Counts cycles in which neither stream moves an item.
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Frame building and sending. A frame is assembled in frame_q and then
    // sent byte by byte, the last byte with tlast.
    // ------------------------------------------------------------------------
    logic [7:0] frame_q [$];

    function automatic void open_request(input logic [7:0] addr, input logic [7:0] fc,
                                         input logic [15:0] w1, input logic [15:0] w2);
        frame_q.delete();
        frame_q.push_back(addr);
        frame_q.push_back(fc);
        frame_q.push_back(w1[15:8]);
        frame_q.push_back(w1[7:0]);
        frame_q.push_back(w2[15:8]);
        frame_q.push_back(w2[7:0]);
    endfunction

    // Appends the byte count and n random payload bytes.
    function automatic void add_payload(input logic [7:0] cnt, input int n);
        frame_q.push_back(cnt);
        repeat (n) frame_q.push_back(8'($urandom));
    endfunction

    // Appends the CRC, low byte first.
    function automatic void seal_frame();
        logic [15:0] c;
        c = CRC_INIT;
        foreach (frame_q[i]) c = crc16_next(c, frame_q[i]);
        frame_q.push_back(c[7:0]);
        frame_q.push_back(c[15:8]);
    endfunction

    function automatic void fill_random(input int n);
        frame_q.delete();
        repeat (n) frame_q.push_back(8'($urandom));
    endfunction

    // Presents one item and waits for its handshake. An idle gap, if any,
    // comes before the item, so tvalid is never dropped and raised in one step.
    task automatic send_item(input logic [7:0] b, input logic last);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        track_rx_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_q[i]) send_item(frame_q[i], i == frame_q.size() - 1);
    endtask

    task automatic send_request(input logic [7:0] addr, input logic [7:0] fc,
                                input logic [15:0] w1, input logic [15:0] w2);
        open_request(addr, fc, w1, w2);
        seal_frame();
        send_frame();
    endtask

    // Stops sending until every outstanding result has been taken, then
    // lets the latency of the block run out.
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The station address is only written between frames with nothing in
    // flight.
    task automatic set_station(input logic [7:0] addr);
        hold_until_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= addr;
        @(posedge i_clk);
        station_addr = addr;
        i_cfg_wr_en  <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Every supported function code accepted, with field extremes, at the
    // station address left by reset.
    task automatic test_function_codes();
        send_request(station_addr, FC_READ_COILS, 16'hFFFF, MAX_READ_BITS);
        send_request(station_addr, FC_READ_DISCRETE, 16'h0000, 16'd1);
        send_request(station_addr, FC_READ_HOLDING, 16'h1234, MAX_READ_REGS);
        send_request(station_addr, FC_READ_INPUT, 16'h8000, 16'd1);
        send_request(station_addr, FC_WRITE_COIL, 16'h0007, COIL_ON);
        send_request(station_addr, FC_WRITE_COIL, 16'h0007, COIL_OFF);
        send_request(station_addr, FC_WRITE_REG, 16'hFFFF, 16'hFFFF);
        open_request(station_addr, FC_WRITE_COILS, 16'h0013, 16'd10);
        add_payload(8'd2, 2);
        seal_frame();
        send_frame();
        open_request(station_addr, FC_WRITE_REGS, 16'h0001, 16'd2);
        add_payload(8'd4, 4);
        seal_frame();
        send_frame();
    endtask

    // One frame for each way a request is turned down.
    task automatic test_rejections();
        // Too short: one to three bytes.
        fill_random(1);
        send_frame();
        fill_random(3);
        send_frame();
        // Four bytes with a good CRC: the CRC bytes land in the header.
        frame_q.delete();
        frame_q.push_back(station_addr);
        frame_q.push_back(FC_READ_HOLDING);
        seal_frame();
        send_frame();
        // A single flipped bit spoils the CRC.
        open_request(station_addr, FC_READ_HOLDING, 16'h0000, 16'd1);
        seal_frame();
        frame_q[3] = frame_q[3] ^ 8'h01;
        send_frame();
        send_request(station_addr + 8'd1, FC_READ_HOLDING, 16'h0000, 16'd1);
        // The sender waits here until every result so far has come back.
        hold_until_drained();
        // Illegal functions: an exception code and zero.
        send_request(station_addr, EXC_FLAG | FC_READ_HOLDING, 16'h0000, 16'd1);
        send_request(station_addr, 8'h00, 16'h0000, 16'd1);
        // Illegal data values, one for each rule.
        send_request(station_addr, FC_READ_COILS, 16'h0000, 16'd0);
        send_request(station_addr, FC_READ_DISCRETE, 16'h0000, MAX_READ_BITS + 16'd1);
        send_request(station_addr, FC_READ_INPUT, 16'h0000, MAX_READ_REGS + 16'd1);
        send_request(station_addr, FC_WRITE_COIL, 16'h0000, 16'h1234);
        open_request(station_addr, FC_WRITE_REG, 16'h0000, 16'h5555);
        frame_q.push_back(8'h00);   // one byte too many
        seal_frame();
        send_frame();
        open_request(station_addr, FC_WRITE_COILS, 16'h0000, 16'd9);
        add_payload(8'd1, 1);       // nine coils need two bytes
        seal_frame();
        send_frame();
        open_request(station_addr, FC_WRITE_COILS, 16'h0000, MAX_WRITE_BITS + 16'd1);
        add_payload(8'd247, 0);
        seal_frame();
        send_frame();
        open_request(station_addr, FC_WRITE_REGS, 16'h0000, MAX_WRITE_REGS + 16'd1);
        add_payload(8'd248, 2);
        seal_frame();
        send_frame();
        // Too short for a register write: no byte count or payload follows.
        open_request(station_addr, FC_WRITE_REGS, 16'h0000, 16'd0);
        seal_frame();
        send_frame();
    endtask

    // Station addresses at both ends of the range; address 0 is an ordinary
    // station, not a broadcast.
    task automatic test_station_extremes();
        set_station(8'd0);
        send_request(8'd0, FC_READ_HOLDING, 16'h0010, 16'd3);
        send_request(8'd1, FC_READ_HOLDING, 16'h0010, 16'd3);
        set_station(8'd255);
        send_request(8'd255, FC_WRITE_REG, 16'h0002, 16'hABCD);
        send_request(8'd0, FC_WRITE_REG, 16'h0002, 16'hABCD);
    endtask

    // A frame that exactly fills the buffer, and one that runs past it.
    task automatic test_frame_cap();
        fill_random(FRAME_CAP - 2);
        frame_q[0] = station_addr;
        frame_q[1] = FC_WRITE_REGS;
        seal_frame();
        send_frame();
        fill_random(FRAME_CAP + 1);
        frame_q[0] = station_addr;
        send_frame();
    endtask

    // Quantity near the legal range of a rule: zero, the limit, one past it,
    // anything, or most often a legal value.
    function automatic logic [15:0] pick_quantity(input logic [15:0] limit);
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return limit;
            2:       return limit + 16'd1;
            3:       return 16'($urandom);
            default: return 16'($urandom_range(1, limit));
        endcase
    endfunction

    // Mostly well-formed requests to this station with random content; a few
    // go elsewhere, have odd lengths, bad counts or a corrupted byte.
    function automatic void build_random_request();
        logic [7:0]  addr;
        logic [7:0]  fc;
        logic [7:0]  cnt;
        logic [15:0] qty;
        int          n;
        addr = ($urandom_range(99) < 85) ? station_addr : 8'($urandom);
        if ($urandom_range(99) < 90) begin
            case ($urandom_range(7))
                0: fc = FC_READ_COILS;
                1: fc = FC_READ_DISCRETE;
                2: fc = FC_READ_HOLDING;
                3: fc = FC_READ_INPUT;
                4: fc = FC_WRITE_COIL;
                5: fc = FC_WRITE_REG;
                6: fc = FC_WRITE_COILS;
                default: fc = FC_WRITE_REGS;
            endcase
        end else begin
            fc = 8'($urandom);
        end
        case (fc)
            FC_READ_COILS, FC_READ_DISCRETE: qty = pick_quantity(MAX_READ_BITS);
            FC_READ_HOLDING, FC_READ_INPUT:  qty = pick_quantity(MAX_READ_REGS);
            FC_WRITE_COIL:
                case ($urandom_range(4))
                    0, 1:    qty = COIL_ON;
                    2, 3:    qty = COIL_OFF;
                    default: qty = 16'($urandom);
                endcase
            FC_WRITE_COILS:
                qty = ($urandom_range(9) == 0) ? pick_quantity(MAX_WRITE_BITS)
                                               : 16'($urandom_range(1, 64));
            FC_WRITE_REGS:
                qty = ($urandom_range(9) == 0) ? pick_quantity(MAX_WRITE_REGS)
                                               : 16'($urandom_range(1, 16));
            default: qty = 16'($urandom);
        endcase
        open_request(addr, fc, 16'($urandom), qty);
        if (fc == FC_WRITE_COILS || fc == FC_WRITE_REGS) begin
            cnt = (fc == FC_WRITE_COILS) ? 8'((32'(qty) + 7) / 8) : 8'(32'(qty) * 2);
            if ($urandom_range(9) == 0) cnt = 8'($urandom);
            n = ($urandom_range(9) == 0) ? $urandom_range(0, 3) : int'(cnt);
            add_payload(cnt, n);
        end else if ($urandom_range(9) == 0) begin
            if ($urandom_range(1) == 1)
                frame_q.push_back(8'($urandom));
            else
                void'(frame_q.pop_back());
        end
        seal_frame();
        if ($urandom_range(99) < 8) begin
            n = $urandom_range(frame_q.size() - 1);
            frame_q[n] = frame_q[n] ^ (8'h01 << $urandom_range(7));
        end
    endfunction

    // Random traffic at one idling setting and one station address.
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input logic [7:0] stn, input int byte_budget);
        int stop_at;
        set_station(stn);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        stop_at = bytes_sent + byte_budget;
        while (bytes_sent < stop_at) begin
            case ($urandom_range(99)) inside
                [0:74]: build_random_request();
                [75:97]: begin
                    // Short noise, half of it with a valid CRC.
                    fill_random($urandom_range(1, 12));
                    if ($urandom_range(1) == 1) begin
                        frame_q[0] = station_addr;
                        seal_frame();
                    end
                end
                default: begin
                    // Around the buffer limit.
                    fill_random($urandom_range(FRAME_CAP - 4, FRAME_CAP + 20));
                    if ($urandom_range(1) == 1) seal_frame();
                end
            endcase
            send_frame();
            if ($urandom_range(39) == 0) hold_until_drained();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------------
    initial begin
        clear_frame_state();
        foreach (verdict_tally[i]) verdict_tally[i] = 0;
        // First setting: the sender idles now and then, the receiver often.
        send_idle_pct  = 12;
        recv_stall_pct = 54;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_function_codes();
        test_rejections();
        test_station_extremes();
        test_frame_cap();

        test_random_traffic(12, 54, 8'($urandom), 150);
        test_random_traffic(54, 12, 8'hA5, 150);
        test_random_traffic(0, 0, 8'($urandom), 150);

        hold_until_drained();

        $display("Covered %0d frames in %0d bytes, %0d results checked, at station",
                 frames_sent, bytes_sent, results_checked);
        $display("addresses 1, 0, 255 and random; verdicts 0..6 seen %0d %0d %0d %0d %0d %0d %0d",
                 verdict_tally[0], verdict_tally[1], verdict_tally[2], verdict_tally[3],
                 verdict_tally[4], verdict_tally[5], verdict_tally[6]);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/mrc_pkg.sv
rtl/mrc_judge.sv
rtl/modbus_rtu_request_checker.sv
rtl/mrc_checker.sv
test/tb.sv
